>>> rtl/core/bdm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdm_pkg
// Request and status codes shared by the bounded deque with middle peek.
// ----------------------------------------------------------------------------
package bdm_pkg;

  // request codes carried on req_type_i
  typedef enum logic [2:0] {
    REQ_PUSH_FRONT = 3'd0,
    REQ_PUSH_BACK  = 3'd1,
    REQ_POP_FRONT  = 3'd2,
    REQ_POP_BACK   = 3'd3,
    REQ_PEEK_MID   = 3'd4
  } req_e;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // data returned by a pop or peek on an empty store
  localparam logic signed [31:0] EMPTY_DATA = -32'sd1;

  localparam int unsigned CountOutW = 7;

endpackage

>>> rtl/core/bounded_deque_with_middle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_deque_with_middle
// Bounded double-ended queue of signed 32-bit values in a ring memory, with
// push/pop at both ends and a peek at the middle element.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start_i high and busy_o low.
//   busy_o stays low, so a request may be issued in every cycle.
//   req_type_i selects push front, push back, pop front, pop back or peek
//   middle; push_value_i is the value stored by a push.
//   Every request gives exactly one result in the next cycle: done_o is high
//   for that single cycle while data_out_o, status_o and count_out_o hold
//   the result. The receiver cannot stall; results must be taken when shown.
//   Throughput is 1 request per cycle. The ring memory has one port; each
//   request does at most a single read or a single write, and the registered
//   read data feeds data_out_o with no further register.
//   A push into a full store is dropped with status full; a pop or peek on
//   an empty store returns -1 with status empty. Unknown codes do nothing.
//   Reset empties the deque at once (front index and count cleared); the
//   memory itself is not cleared, and no entry is read before written.
// ----------------------------------------------------------------------------
module bounded_deque_with_middle #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [2:0]          req_type_i,
  input  logic signed [31:0]  push_value_i,
  output logic                done_o,
  output logic signed [31:0]  data_out_o,
  output logic [1:0]          status_o,
  output logic [6:0]          count_out_o
);
  import bdm_pkg::*;

  localparam int unsigned IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx  = IdxW'(DEPTH - 1);
  localparam logic [IdxW:0]   DepthExt = (IdxW + 1)'(DEPTH);
  localparam logic [CntW-1:0] DepthCnt = CntW'(DEPTH);

  // ring memory, undefined until written
  logic signed [31:0] mem_q [DEPTH];
  logic signed [31:0] rd_data_q;

  logic [IdxW-1:0] front_q, front_d;
  logic [CntW-1:0] count_q, count_d;

  logic            done_q;
  logic            rd_hit_q;
  status_e         status_q;
  logic [6:0]      cnt_out_q;

  logic            accept;
  logic            is_full, is_empty;
  logic            wr_en, rd_en, rd_hit_d;
  status_e         status_d;
  logic [IdxW-1:0] mem_addr;
  logic [IdxW-1:0] front_inc, front_dec;
  logic [IdxW-1:0] ring_ofs, ring_addr;
  logic [IdxW:0]   ring_sum;
  logic [CntW-1:0] count_dec;
  logic [CntW+6:0] cnt_ext;

  assign busy_o   = 1'b0;
  assign accept   = start_i && !busy_o;
  assign is_full  = (count_q == DepthCnt);
  assign is_empty = (count_q == '0);

  // step the front pointer around the ring
  assign front_inc = (front_q == LastIdx) ? '0 : front_q + 1'b1;
  assign front_dec = (front_q == '0) ? LastIdx : front_q - 1'b1;
  assign count_dec = count_q - 1'b1;

  // offset from the front: back slot, last element or middle
  always_comb begin
    unique case (req_type_i)
      REQ_PUSH_BACK: ring_ofs = count_q[IdxW-1:0];
      REQ_POP_BACK:  ring_ofs = count_dec[IdxW-1:0];
      default:       ring_ofs = count_q[CntW-1:1];
    endcase
  end

  // wrap front plus offset with one compare and subtract
  assign ring_sum  = {1'b0, front_q} + {1'b0, ring_ofs};
  assign ring_addr = (ring_sum >= DepthExt) ? IdxW'(ring_sum - DepthExt)
                                             : ring_sum[IdxW-1:0];

  // decode the request
  always_comb begin
    front_d  = front_q;
    count_d  = count_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    rd_hit_d = 1'b0;
    status_d = ST_OK;
    mem_addr = ring_addr;
    unique case (req_type_i)
      REQ_PUSH_FRONT, REQ_PUSH_BACK: begin
        if (is_full) begin
          status_d = ST_FULL;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (req_type_i == REQ_PUSH_FRONT) begin
            front_d  = front_dec;
            mem_addr = front_dec;
          end
        end
      end
      REQ_POP_FRONT, REQ_POP_BACK, REQ_PEEK_MID: begin
        if (is_empty) begin
          status_d = ST_EMPTY;
        end else begin
          rd_en    = 1'b1;
          rd_hit_d = 1'b1;
          if (req_type_i == REQ_POP_FRONT) begin
            mem_addr = front_q;
            front_d  = front_inc;
            count_d  = count_dec;
          end else if (req_type_i == REQ_POP_BACK) begin
            count_d  = count_dec;
          end
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  assign cnt_ext = {7'b0, count_d};

  // ring memory: at most one write or one registered read per request
  always_ff @(posedge clk_i) begin
    if (accept && wr_en) begin
      mem_q[mem_addr] <= push_value_i;
    end
    if (accept && rd_en) begin
      rd_data_q <= mem_q[mem_addr];
    end
  end

  // advance pointer and count, register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q   <= '0;
      count_q   <= '0;
      done_q    <= 1'b0;
      rd_hit_q  <= 1'b0;
      status_q  <= ST_OK;
      cnt_out_q <= '0;
    end else begin
      done_q <= accept;
      if (accept) begin
        front_q   <= front_d;
        count_q   <= count_d;
        rd_hit_q  <= rd_hit_d;
        status_q  <= status_d;
        cnt_out_q <= cnt_ext[6:0];
      end
    end
  end

  // drive result ports
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign count_out_o = cnt_out_q;
  assign data_out_o  = rd_hit_q ? rd_data_q
                     : ((status_q == ST_EMPTY) ? EMPTY_DATA : 32'sd0);

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthCnt)
    else $error("element count above depth");

  a_front_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_q <= LastIdx)
    else $error("front index outside ring");

  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result without request");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && is_full && (req_type_i == REQ_PUSH_FRONT ||
     req_type_i == REQ_PUSH_BACK)) |=> (status_o == ST_FULL && $stable(count_q)))
    else $error("push into full store changed state");

  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_EMPTY) |-> (data_out_o == EMPTY_DATA && !rd_hit_q))
    else $error("empty result carries data");
`endif

endmodule
